// File: design/vtst_pkg.sv
// ----------------------------------------------------------------------------
// virtual touch stick tracker package
// shared widths, codes and payload types of the stick tracker
// ----------------------------------------------------------------------------
package vtst_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ID_BITS      = 8;
    localparam int OUT_W        = 16;
    // deflection search runs over this many quotient bits, result limited to full scale
    localparam int Q_BITS       = 15;
    localparam int FULL_SCALE   = 16384;
    localparam int CNT_W        = $clog2(Q_BITS);

    // squared coordinate difference and sum of two of them
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int S_W          = SQ_W + 1;

    // shared multiplier operands and product
    localparam int MA_W         = S_W;
    localparam int MB_W         = SQ_W;
    localparam int MP_W         = MA_W + MB_W;

    // 25 * m2 and 441 * a^2, gain 4.2 squared is 441/25
    localparam int K_AREA       = 25;
    localparam int K_GAIN       = 441;
    localparam int P_W          = S_W + 5;
    localparam int R_W          = SQ_W + 9;
    localparam int GAIN_SHIFT   = 28;
    localparam int SEARCH_SHIFT = 2 * (Q_BITS - 1);
    localparam int CMP_W        = SQ_W + 38;

    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 2'd0,
        CFG_CENTER_Y    = 2'd1,
        CFG_AREA_WIDTH  = 2'd2,
        CFG_AREA_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  touch_active;
        logic                  touch_released;
        logic                  touch_started;
        logic [COORD_BITS-1:0] touch_x;
        logic [COORD_BITS-1:0] touch_y;
        logic [ID_BITS-1:0]    touch_tag;
        logic                  no_record;
        logic                  last_in_frame;
    } t_touch_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] stick_horizontal;
        logic signed [OUT_W-1:0] stick_vertical;
        logic                    stick_engaged;
    } t_stick;

    typedef struct packed {
        logic           start;
        logic [P_W-1:0] p;
        logic [R_W-1:0] r;
    } t_defl_req;

    typedef struct packed {
        logic              busy;
        logic [Q_BITS-1:0] q;
    } t_defl_rsp;

endpackage

// File: design/vtst_mul.sv
// ----------------------------------------------------------------------------
// shared multiplier
// one registered multiply per cycle, operands chosen by the sequencer
// ----------------------------------------------------------------------------
module vtst_mul (
    input  logic                      i_clk,
    input  logic [vtst_pkg::MA_W-1:0] i_a,
    input  logic [vtst_pkg::MB_W-1:0] i_b,
    output logic [vtst_pkg::MP_W-1:0] o_p
);
    import vtst_pkg::*;

    logic [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: design/vtst_defl.sv
// ----------------------------------------------------------------------------
// deflection search unit
// bit-serial search for the largest q with p*q^2 <= r*2^28, one bit a cycle
// ----------------------------------------------------------------------------
module vtst_defl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vtst_pkg::t_defl_req  i_req,
    output vtst_pkg::t_defl_rsp  o_rsp
);
    import vtst_pkg::*;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [CMP_W-1:0]  r_t;
    logic [CMP_W-1:0]  r_us;
    logic [CMP_W-1:0]  r_ps;
    logic [CMP_W-1:0]  r_lim;
    logic [Q_BITS-1:0] r_q;
    logic [CMP_W-1:0]  n_cand;
    logic              n_ok;

    // r_t = p*q^2, r_us = p*q << (bit+1), r_ps = p << 2*bit
    assign n_cand = r_t + r_us + r_ps;
    assign n_ok   = (n_cand <= r_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(Q_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_t   <= '0;
            r_us  <= '0;
            r_ps  <= CMP_W'(i_req.p) << SEARCH_SHIFT;
            r_lim <= CMP_W'(i_req.r) << GAIN_SHIFT;
            r_q   <= '0;
        end else if (r_busy) begin
            if (n_ok) begin
                r_t        <= n_cand;
                r_q[r_cnt] <= 1'b1;
                r_us       <= (r_us >> 1) + r_ps;
            end else begin
                r_us <= r_us >> 1;
            end
            r_ps <= r_ps >> 2;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.q    = r_q;

endmodule

// File: design/virtual_touch_stick_tracker.sv
// ----------------------------------------------------------------------------
// virtual touch stick tracker
// turns a frame's touch records into a virtual joystick deflection
// ----------------------------------------------------------------------------
// usage
//   input channel: one touch record per transaction (i_in_valid, o_in_stall),
//   frames closed by last_in_frame; output channel: at most one stick value
//   per record (o_out_valid, i_out_stall); config channel: four area
//   registers written with i_cfg_valid / o_cfg_ready; the user writes them
//   only while idle, which the block itself leaves unchecked
// sequencing
//   a record with no marks, or one arriving after the frame is answered,
//   is handled in the idle state; a marked record runs squares and the ellipse
//   test on the shared multiplier; a deflection adds the states ST_RX, ST_RY,
//   ST_XGO and two bit-serial searches, x axis then y axis; the sequencer
//   handles one record at a time, o_in_stall is high meanwhile
// reset
//   synchronous, active low: nothing tracked, frame not answered, output
//   empty, area centre 0,0 and size 1 by 1
// output stall
//   the result sits in the output register until taken; the next record is
//   accepted meanwhile and waits in the emit state if it too has a result
// ----------------------------------------------------------------------------
module virtual_touch_stick_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // touch record channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  vtst_pkg::t_touch_item             i_touch,
    // stick value channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output vtst_pkg::t_stick                  o_stick,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vtst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vtst_pkg::COORD_BITS-1:0]   i_cfg_data
);
    import vtst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQW,
        ST_SQH,
        ST_CAPA,
        ST_CAPB,
        ST_CAPC,
        ST_DECIDE,
        ST_RX,
        ST_RY,
        ST_XGO,
        ST_XRUN,
        ST_YRUN,
        ST_EMIT
    } t_state;

    // configuration registers
    logic [COORD_BITS-1:0] r_center_x;
    logic [COORD_BITS-1:0] r_center_y;
    logic [COORD_BITS-1:0] r_area_width;
    logic [COORD_BITS-1:0] r_area_height;

    // control state
    t_state                r_state;
    logic                  r_trk;
    logic [ID_BITS-1:0]    r_tid;
    logic                  r_resolved;
    logic                  r_out_valid;
    t_stick                r_out;
    t_stick                r_res;

    // per transaction datapath
    t_touch_item           r_item;
    logic [COORD_BITS-1:0] r_ax;
    logic [COORD_BITS-1:0] r_ay;
    logic                  r_nx;
    logic                  r_ny;
    logic [SQ_W-1:0]       r_dx2;
    logic [SQ_W-1:0]       r_dy2;
    logic [SQ_W-1:0]       r_w2;
    logic [SQ_W-1:0]       r_h2;
    logic [S_W-1:0]        r_s;
    logic [MP_W-1:0]       r_acc;
    logic [P_W-1:0]        r_p25;
    logic [R_W-1:0]        r_rx;
    logic [R_W-1:0]        r_ry;
    logic [Q_BITS-1:0]     r_qx;

    logic                  n_accept;
    logic                  n_marked;
    logic                  n_tx_lt;
    logic                  n_ty_lt;
    logic                  n_out_free;
    logic [MA_W-1:0]       n_mul_a;
    logic [MB_W-1:0]       n_mul_b;
    logic [MP_W-1:0]       n_prod;
    logic [S_W-1:0]        n_m2;
    logic                  n_inside;
    logic                  n_capt_try;
    logic                  n_cap;
    logic                  n_trk_a;
    logic [ID_BITS-1:0]    n_tid_a;
    logic                  n_match;
    t_defl_req             n_req;
    t_defl_rsp             n_rsp;

    // sign and limit one axis magnitude into q1.14
    function automatic logic [OUT_W-1:0] f_axis(input logic [Q_BITS-1:0] q, input logic neg);
        logic [Q_BITS-1:0] m;
        m = (q > Q_BITS'(FULL_SCALE)) ? Q_BITS'(FULL_SCALE) : q;
        return neg ? (OUT_W'(0) - OUT_W'(m)) : OUT_W'(m);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stick     = r_out;

    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_marked   = !i_touch.no_record &&
                        (i_touch.touch_active || i_touch.touch_released ||
                         i_touch.touch_started);
    assign n_tx_lt    = i_touch.touch_x < r_center_x;
    assign n_ty_lt    = i_touch.touch_y < r_center_y;
    assign n_out_free = !r_out_valid || !i_out_stall;

    // --------------------------------------------------------------------
    // configuration writes
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_area_width  <= COORD_BITS'(1);
            r_area_height <= COORD_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:    r_center_x    <= i_cfg_data;
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data;
                CFG_AREA_WIDTH:  r_area_width  <= i_cfg_data;
                CFG_AREA_HEIGHT: r_area_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // shared multiplier, operand selection per sequencer step
    // --------------------------------------------------------------------
    // deflection uses h^2 while the touch lies within distance h of the centre
    assign n_m2 = ((r_area_height != '0) && (S_W'(r_h2) > r_s)) ? S_W'(r_h2) : r_s;

    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            ST_SQX: begin
                n_mul_a = MA_W'(r_ax);
                n_mul_b = MB_W'(r_ax);
            end
            ST_SQY: begin
                n_mul_a = MA_W'(r_ay);
                n_mul_b = MB_W'(r_ay);
            end
            ST_SQW: begin
                n_mul_a = MA_W'(r_area_width);
                n_mul_b = MB_W'(r_area_width);
            end
            ST_SQH: begin
                n_mul_a = MA_W'(r_area_height);
                n_mul_b = MB_W'(r_area_height);
            end
            ST_CAPA: begin
                // product currently holds h^2
                n_mul_a = MA_W'(r_dx2);
                n_mul_b = n_prod[MB_W-1:0];
            end
            ST_CAPB: begin
                n_mul_a = MA_W'(r_dy2);
                n_mul_b = r_w2;
            end
            ST_CAPC: begin
                n_mul_a = MA_W'(r_w2);
                n_mul_b = r_h2;
            end
            ST_DECIDE: begin
                n_mul_a = n_m2;
                n_mul_b = MB_W'(K_AREA);
            end
            ST_RX: begin
                n_mul_a = MA_W'(r_dx2);
                n_mul_b = MB_W'(K_GAIN);
            end
            ST_RY: begin
                n_mul_a = MA_W'(r_dy2);
                n_mul_b = MB_W'(K_GAIN);
            end
            default: ;
        endcase
    end

    vtst_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (n_prod)
    );

    // --------------------------------------------------------------------
    // deflection search, x axis first then y axis
    // --------------------------------------------------------------------
    assign n_req.start = (r_state == ST_XGO) || ((r_state == ST_XRUN) && !n_rsp.busy);
    assign n_req.p     = r_p25;
    assign n_req.r     = (r_state == ST_XGO) ? r_rx : r_ry;

    vtst_defl u_defl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    // --------------------------------------------------------------------
    // capture and tracking decision
    // --------------------------------------------------------------------
    // inside the ellipse when 4*(dx^2*h^2 + dy^2*w^2) <= w^2*h^2
    assign n_inside   = {r_acc, 2'b00} <= (MP_W + 2)'(n_prod);
    assign n_capt_try = !r_trk && r_item.touch_started &&
                        (r_area_width != '0) && (r_area_height != '0);
    assign n_cap      = n_capt_try && n_inside;
    assign n_trk_a    = r_trk || n_cap;
    assign n_tid_a    = n_cap ? r_item.touch_tag : r_tid;
    assign n_match    = (n_tid_a == r_item.touch_tag);

    // --------------------------------------------------------------------
    // datapath registers
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_item <= i_touch;
            r_nx   <= n_tx_lt;
            r_ny   <= n_ty_lt;
            r_ax   <= n_tx_lt ? (r_center_x - i_touch.touch_x) : (i_touch.touch_x - r_center_x);
            r_ay   <= n_ty_lt ? (r_center_y - i_touch.touch_y) : (i_touch.touch_y - r_center_y);
        end
        case (r_state)
            ST_SQY:  r_dx2 <= n_prod[SQ_W-1:0];
            ST_SQW:  r_dy2 <= n_prod[SQ_W-1:0];
            ST_SQH: begin
                r_w2 <= n_prod[SQ_W-1:0];
                r_s  <= S_W'(r_dx2) + S_W'(r_dy2);
            end
            ST_CAPA: r_h2  <= n_prod[SQ_W-1:0];
            ST_CAPB: r_acc <= n_prod;
            ST_CAPC: r_acc <= r_acc + n_prod;
            ST_RX:   r_p25 <= n_prod[P_W-1:0];
            ST_RY:   r_rx  <= n_prod[R_W-1:0];
            ST_XGO:  r_ry  <= n_prod[R_W-1:0];
            ST_XRUN: begin
                if (!n_rsp.busy) begin
                    r_qx <= n_rsp.q;
                end
            end
            default: ;
        endcase
    end

    // --------------------------------------------------------------------
    // sequencer, tracking state and output register
    // --------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_trk       <= 1'b0;
            r_tid       <= '0;
            r_resolved  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains when taken, the emit state refills it itself
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (r_resolved) begin
                            // frame already answered, only its end matters
                            if (i_touch.last_in_frame) begin
                                r_resolved <= 1'b0;
                            end
                        end else if (n_marked) begin
                            r_state <= ST_SQX;
                        end else if (i_touch.last_in_frame) begin
                            r_trk   <= 1'b0;
                            r_res   <= '0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_SQX:  r_state <= ST_SQY;
                ST_SQY:  r_state <= ST_SQW;
                ST_SQW:  r_state <= ST_SQH;
                ST_SQH:  r_state <= ST_CAPA;
                ST_CAPA: r_state <= ST_CAPB;
                ST_CAPB: r_state <= ST_CAPC;
                ST_CAPC: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    r_tid <= n_tid_a;
                    if (r_item.touch_released && n_match) begin
                        // release of the tracked finger, capture first if both
                        r_trk <= 1'b0;
                        if (r_item.last_in_frame) begin
                            r_res   <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else if (n_trk_a && n_match) begin
                        r_trk      <= 1'b1;
                        r_resolved <= !r_item.last_in_frame;
                        r_state    <= ST_RX;
                    end else if (r_item.last_in_frame) begin
                        r_trk   <= 1'b0;
                        r_res   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_trk   <= n_trk_a;
                        r_state <= ST_IDLE;
                    end
                end
                ST_RX:   r_state <= ST_RY;
                ST_RY:   r_state <= ST_XGO;
                ST_XGO:  r_state <= ST_XRUN;
                ST_XRUN: begin
                    if (!n_rsp.busy) begin
                        r_state <= ST_YRUN;
                    end
                end
                ST_YRUN: begin
                    if (!n_rsp.busy) begin
                        // touch exactly at the centre gives no deflection
                        if (r_s == '0) begin
                            r_res.stick_horizontal <= '0;
                            r_res.stick_vertical   <= '0;
                        end else begin
                            r_res.stick_horizontal <= $signed(f_axis(r_qx, r_nx));
                            r_res.stick_vertical   <= $signed(f_axis(n_rsp.q, r_ny));
                        end
                        r_res.stick_engaged <= 1'b1;
                        r_state             <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    // a frame closed without a tracked touch reports a centred stick
    a_zero_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_stick.stick_engaged) |->
            (o_stick.stick_horizontal == '0) && (o_stick.stick_vertical == '0))
        else $error("disengaged stick value is not zero");

    // deflection never exceeds full scale
    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_stick.stick_horizontal <= 16'sd16384) &&
            (o_stick.stick_horizontal >= -16'sd16384) &&
            (o_stick.stick_vertical <= 16'sd16384) &&
            (o_stick.stick_vertical >= -16'sd16384))
        else $error("stick deflection beyond full scale");

    // the y search follows the x search without a gap
    a_y_follows_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_XRUN) && !n_rsp.busy) |=> n_rsp.busy)
        else $error("y axis search not started after x axis");

    // a frame is marked answered only by a tracking decision
    a_resolved_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_resolved) |-> ($past(r_state) == ST_DECIDE))
        else $error("frame marked answered outside the decision step");

endmodule

// File: tb/sv/stick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick tracker checker
// follows the record and config channels, predicts every stick value and
// compares it with what the output channel delivers
// ----------------------------------------------------------------------------
module stick_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  vtst_pkg::t_touch_item           i_touch,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  vtst_pkg::t_stick                i_stick,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [vtst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vtst_pkg::COORD_BITS-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_errors
);
    import vtst_pkg::*;

    // 16384 * 4.2 * 5, and 441 * 2^28 for the squared comparison
    localparam longint unsigned GAIN_X5   = 64'd344064;
    localparam longint unsigned GAIN_SQR  = 64'd118380036096;

    logic [COORD_BITS-1:0] area_cx, area_cy, area_w, area_h;
    logic                  is_tracking;
    logic [ID_BITS-1:0]    held_id;
    logic                  frame_done;

    t_stick stick_due[$];
    int     fail_count = 0;

    // magnitude of one axis in q1.14, truncated and limited to full scale
    function automatic logic [OUT_W-1:0] deflection_mag(input longint unsigned a,
                                                        input longint unsigned s);
        longint unsigned h, q, lo, hi, mid;
        h = 64'(area_h);
        if (s == 0)
            return '0;
        if (h != 0 && s < h * h) begin
            q = (GAIN_X5 * a) / (64'd5 * h);
            return (q > FULL_SCALE) ? OUT_W'(FULL_SCALE) : OUT_W'(q);
        end
        // largest q with 25 q^2 s <= 441 2^28 a^2
        lo = '0;
        hi = 64'(FULL_SCALE);
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) / 64'd2;
            if (64'd25 * mid * mid * s <= GAIN_SQR * a * a)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return OUT_W'(lo);
    endfunction

    // advances the tracking state by one record, returns 1 if it answers
    function automatic bit follow_touch(input t_touch_item t, output t_stick res);
        logic             nx, ny;
        longint unsigned  ax, ay, dx2, dy2, w2, h2;
        logic [OUT_W-1:0] mag_x, mag_y;
        res = '0;
        if (frame_done) begin
            if (t.last_in_frame)
                frame_done = 1'b0;
            return 1'b0;
        end
        if (!t.no_record && (t.touch_active || t.touch_released || t.touch_started)) begin
            nx  = t.touch_x < area_cx;
            ny  = t.touch_y < area_cy;
            ax  = nx ? 64'(area_cx) - 64'(t.touch_x) : 64'(t.touch_x) - 64'(area_cx);
            ay  = ny ? 64'(area_cy) - 64'(t.touch_y) : 64'(t.touch_y) - 64'(area_cy);
            dx2 = ax * ax;
            dy2 = ay * ay;
            // capture needs the touch inside the ellipse, tested exactly
            if (!is_tracking && t.touch_started && area_w != 0 && area_h != 0) begin
                w2 = 64'(area_w) * 64'(area_w);
                h2 = 64'(area_h) * 64'(area_h);
                if (64'd4 * dx2 * h2 + 64'd4 * dy2 * w2 <= w2 * h2) begin
                    held_id     = t.touch_tag;
                    is_tracking = 1'b1;
                end
            end
            if (t.touch_released && held_id == t.touch_tag) begin
                is_tracking = 1'b0;
            end else if (is_tracking && held_id == t.touch_tag) begin
                mag_x = deflection_mag(ax, dx2 + dy2);
                mag_y = deflection_mag(ay, dx2 + dy2);
                res.stick_horizontal = nx ? -mag_x : mag_x;
                res.stick_vertical   = ny ? -mag_y : mag_y;
                res.stick_engaged    = 1'b1;
                if (!t.last_in_frame)
                    frame_done = 1'b1;
                return 1'b1;
            end
        end
        // frame closes without the tracked touch
        if (t.last_in_frame) begin
            is_tracking = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_stick fresh, want;
        if (!i_rst_n) begin
            area_cx     = '0;
            area_cy     = '0;
            area_w      = COORD_BITS'(1);
            area_h      = COORD_BITS'(1);
            is_tracking = 1'b0;
            held_id     = '0;
            frame_done  = 1'b0;
            stick_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTER_X:    area_cx = i_cfg_data;
                    CFG_CENTER_Y:    area_cy = i_cfg_data;
                    CFG_AREA_WIDTH:  area_w  = i_cfg_data;
                    CFG_AREA_HEIGHT: area_h  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (follow_touch(i_touch, fresh))
                    stick_due.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (stick_due.size() == 0) begin
                    $error("unexpected stick value: %0d %0d %0d", i_stick.stick_horizontal,
                           i_stick.stick_vertical, i_stick.stick_engaged);
                    fail_count++;
                end else begin
                    want = stick_due.pop_front();
                    if (want.stick_horizontal !== i_stick.stick_horizontal) begin
                        $error("stick_horizontal: expected %0d, got %0d",
                               want.stick_horizontal, i_stick.stick_horizontal);
                        fail_count++;
                    end
                    if (want.stick_vertical !== i_stick.stick_vertical) begin
                        $error("stick_vertical: expected %0d, got %0d",
                               want.stick_vertical, i_stick.stick_vertical);
                        fail_count++;
                    end
                    if (want.stick_engaged !== i_stick.stick_engaged) begin
                        $error("stick_engaged: expected %0d, got %0d",
                               want.stick_engaged, i_stick.stick_engaged);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= stick_due.size();
        o_errors  <= fail_count;
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick tracker testbench
// directed frames for captures, releases and ignored records, then random
// finger sessions with noise over several capture areas, with random gaps
// on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;
    import vtst_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 64;   // beyond a marked record's run through the sequencer
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_RECORDS  = 250;
    localparam int N_PHASES       = 8;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_touch_item           touch     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_stick                stick;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data  = '0;

    int pending;
    int errors;

    // pacing shared by both channels; pace_random and hold_asked are written by the stimulus
    bit pace_random = 1'b1;
    int hold_asked  = 0;
    int hold_served = 0;
    int idle_cycles = 0;
    int records_sent = 0;

    // capture area in force and the finger being played
    int                 cur_cx, cur_cy, cur_w, cur_h;
    bit                 finger_down = 1'b0;
    logic [ID_BITS-1:0] finger_id   = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    virtual_touch_stick_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_touch     (touch),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_stick     (stick),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stick_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_touch     (touch),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_stick     (stick),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // output side: random stall stretches, or one long hold-off on request
    initial begin : out_pacing
        int n;
        forever begin
            n = 1;
            if (hold_asked != hold_served) begin
                hold_served++;
                n = LONG_HOLD;
                out_stall <= 1'b1;
            end else if (pace_random && $urandom_range(0, 2) == 0) begin
                n = pick_gap() + 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
            repeat (n) @(posedge clk);
        end
    end

    // offers one record and waits for its transaction; valid stays high after
    // so back-to-back records need no second assignment in the same step
    task automatic send_touch(input t_touch_item t);
        int gap;
        gap = pace_random ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        touch    <= t;
        do
            @(posedge clk);
        while (in_stall);
        records_sent++;
    endtask

    // stop offering, wait for every stick value, then let the sequencer settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // valid is left high across the four writes and dropped once at the end
    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[COORD_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_area(input int cx, input int cy, input int w, input int h);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_AREA_WIDTH, w);
        write_reg(CFG_AREA_HEIGHT, h);
        cfg_valid <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        cur_w  = w;
        cur_h  = h;
    endtask

    function automatic t_touch_item make_touch(input int act, input int rel, input int sta,
                                               input int x, input int y, input int id,
                                               input int norec, input int last);
        t_touch_item t;
        t.touch_active   = 1'(act);
        t.touch_released = 1'(rel);
        t.touch_started  = 1'(sta);
        t.touch_x        = COORD_BITS'(x);
        t.touch_y        = COORD_BITS'(y);
        t.touch_tag      = ID_BITS'(id);
        t.no_record      = 1'(norec);
        t.last_in_frame  = 1'(last);
        return t;
    endfunction

    // coordinate within span of centre, clipped to the screen
    function automatic logic [COORD_BITS-1:0] offset_coord(input int centre, input int span);
        int off;
        int v;
        off = $urandom_range(0, span);
        if ($urandom_range(0, 1))
            off = -off;
        v = centre + off;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return COORD_BITS'(v);
    endfunction

    // next record of the played finger: lands inside the area, moves, lifts
    function automatic t_touch_item finger_record();
        t_touch_item t;
        t = '0;
        if (!finger_down) begin
            finger_id       = ID_BITS'($urandom_range(0, 255));
            finger_down     = 1'b1;
            t.touch_started = 1'b1;
            t.touch_active  = 1'($urandom_range(0, 1));
            t.touch_x       = offset_coord(cur_cx, cur_w / 4);
            t.touch_y       = offset_coord(cur_cy, cur_h / 4);
            // a few fingers lift in the frame they land
            if ($urandom_range(0, 19) == 0) begin
                t.touch_released = 1'b1;
                finger_down      = 1'b0;
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                t.touch_released = 1'b1;
                finger_down      = 1'b0;
            end else begin
                t.touch_active = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                t.touch_x = COORD_BITS'($urandom_range(0, COORD_MAX));
                t.touch_y = COORD_BITS'($urandom_range(0, COORD_MAX));
            end else begin
                t.touch_x = offset_coord(cur_cx, $urandom_range(0, 2 * cur_h));
                t.touch_y = offset_coord(cur_cy, $urandom_range(0, 2 * cur_h));
            end
        end
        t.touch_tag = finger_id;
        return t;
    endfunction

    // other fingers, unmarked records and empty-frame markers
    function automatic t_touch_item noise_record();
        t_touch_item t;
        int pick;
        t.touch_active   = 1'($urandom_range(0, 1));
        t.touch_released = 1'($urandom_range(0, 1));
        t.touch_started  = 1'($urandom_range(0, 1));
        t.touch_x        = COORD_BITS'($urandom_range(0, COORD_MAX));
        t.touch_y        = COORD_BITS'($urandom_range(0, COORD_MAX));
        t.touch_tag      = ($urandom_range(0, 3) == 0) ? finger_id
                                                       : ID_BITS'($urandom_range(0, 255));
        t.no_record      = ($urandom_range(0, 4) == 0);
        t.last_in_frame  = 1'b0;
        pick = $urandom_range(0, 6);
        if (pick == 0) begin
            t.touch_active   = 1'b0;
            t.touch_released = 1'b0;
            t.touch_started  = 1'b0;
        end else if (pick == 1) begin
            // stray finger landing inside the area
            t.touch_started  = 1'b1;
            t.touch_released = 1'b0;
            t.touch_x        = offset_coord(cur_cx, cur_w / 2);
            t.touch_y        = offset_coord(cur_cy, cur_h / 2);
        end
        return t;
    endfunction

    task automatic play_frame();
        int  n_records, finger_slot, k;
        bit  with_finger;
        t_touch_item t;
        n_records   = $urandom_range(1, 4);
        with_finger = finger_down ? ($urandom_range(0, 11) != 0) : ($urandom_range(0, 9) < 7);
        // a frame without the held finger drops its tracking
        if (!with_finger)
            finger_down = 1'b0;
        finger_slot = with_finger ? $urandom_range(0, n_records - 1) : -1;
        for (k = 0; k < n_records; k++) begin
            t = (k == finger_slot) ? finger_record() : noise_record();
            t.last_in_frame = (k == n_records - 1);
            send_touch(t);
        end
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: area 800 x 600 around the screen centre
        load_area(2048, 2048, 800, 600);
        send_touch(make_touch(0, 0, 0, 2048, 2048, 42, 0, 1));   // unmarked record ends frame
        send_touch(make_touch(1, 0, 1, 2048, 2048, 42, 1, 0));   // empty marker mid frame
        send_touch(make_touch(0, 0, 0, 0, 0, 0, 1, 1));          // empty frame
        send_touch(make_touch(0, 0, 1, 2449, 2048, 42, 0, 1));   // just outside the ellipse
        send_touch(make_touch(0, 0, 1, 2448, 2048, 42, 0, 0));   // on the edge, captured
        send_touch(make_touch(1, 0, 1, 2048, 2048, 9, 0, 1));    // ignored after answer
        send_touch(make_touch(1, 0, 0, 2048, 2048, 42, 0, 1));   // touch at centre
        send_touch(make_touch(1, 0, 0, 0, COORD_MAX, 42, 0, 0)); // far corner, saturated
        send_touch(make_touch(1, 1, 1, 2048, 2048, 42, 0, 1));   // ignored, closes frame
        send_touch(make_touch(1, 0, 0, 2148, 1998, 42, 0, 1));   // within the area height of the centre
        send_touch(make_touch(1, 0, 0, 2100, 2100, 5, 0, 0));    // other finger
        send_touch(make_touch(0, 1, 0, 2100, 2100, 42, 0, 1));   // release of tracked finger
        send_touch(make_touch(0, 1, 1, 2048, 2048, 7, 0, 1));    // start and release together
        send_touch(make_touch(0, 0, 1, 2048, 2348, 255, 0, 0));  // vertical edge, captured
        send_touch(make_touch(1, 0, 0, COORD_MAX, COORD_MAX, 255, 0, 1));
        send_touch(make_touch(1, 0, 0, 2000, 2000, 3, 0, 1));    // frame without it, cleared
        send_touch(make_touch(1, 0, 0, 2000, 2000, 255, 0, 1));  // no longer tracked
        send_touch(make_touch(1, 1, 1, COORD_MAX, COORD_MAX, 255, 1, 1));
        send_touch(make_touch(0, 0, 1, 0, 0, 0, 0, 1));          // origin, outside
        drain();

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: load_area(0, 0, 1, 1);
                1: load_area(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                2: load_area(2048, 2048, COORD_MAX, COORD_MAX);
                3: load_area(2048, 2048, 1, 1);
                4: load_area(COORD_MAX, 0, COORD_MAX, 1);
                5: load_area(0, COORD_MAX, 1, COORD_MAX);
                default: load_area($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                   $urandom_range(1, COORD_MAX), $urandom_range(1, 600));
            endcase
            finger_down = 1'b0;
            // one long output hold-off while records keep coming back to back
            if (phase == 2) begin
                pace_random = 1'b0;
                hold_asked++;
            end
            phase_start = records_sent;
            while (records_sent - phase_start < PHASE_RECORDS) begin
                if ($urandom_range(0, 39) == 0)
                    pace_random = !pace_random;
                play_frame();
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: sim.f
design/vtst_pkg.sv
design/vtst_mul.sv
design/vtst_defl.sv
design/virtual_touch_stick_tracker.sv
tb/sv/stick_checker.sv
tb/sv/testbench.sv
